FILE: hw/rtl/modexp_pkg.sv
// ----------------------------------------------------------------------------
// Modular exponentiation package
// Shared widths, sequencer states and status types for the modular
// exponentiation block and its modular multiplier.
// ----------------------------------------------------------------------------
package modexp_pkg;

    localparam int WIDTH     = 64;
    localparam int CNT_W     = $clog2(WIDTH);
    localparam int FIELD_W   = 64;
    localparam int IN_DATA_W = 3 * FIELD_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_SQUARE,
        ST_MULT,
        ST_DONE
    } modexp_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mm_status_t;

endpackage

FILE: hw/rtl/modular_exponentiation.sv
// ----------------------------------------------------------------------------
// Modular exponentiation
// Computes base^exponent mod modulus by left-to-right square-and-multiply on
// one shared bit-serial modular multiplier.
// ----------------------------------------------------------------------------
// The run time is set by the multiplier, which takes one step per operand bit
// plus one handoff per product (base reduction, one square per exponent bit,
// one multiply per set bit). A zero modulus skips the multiplier and goes
// straight to the done state. One item is in flight at a time, so a new input
// transaction is taken only after the last result is loaded into the output
// register, which frees the input side. Reset is asynchronous.
module modular_exponentiation
    import modexp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // Fields from bit 0: base_value, exponent_value, modulus_value.
    input  logic [IN_DATA_W-1:0] s_axis_tdata,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // Fields from bit 0: power_result.
    output logic [FIELD_W-1:0]   m_axis_tdata,
    // Fields from bit 0: zero_modulus_error.
    output logic                 m_axis_tuser
);

    modexp_state_t    state_reg;
    modexp_state_t    state_next;
    logic [WIDTH-1:0] exp_reg;
    logic [WIDTH-1:0] exp_next;
    logic [WIDTH-1:0] m_reg;
    logic [WIDTH-1:0] base_reg;
    logic [CNT_W-1:0] bitcnt_reg;
    logic [CNT_W-1:0] bitcnt_next;
    logic [WIDTH-1:0] result_reg;
    logic             err_reg;
    logic [WIDTH-1:0] out_data_reg;
    logic             out_err_reg;
    logic             out_valid_reg;

    logic [WIDTH-1:0] base_in;
    logic [WIDTH-1:0] exp_in;
    logic [WIDTH-1:0] m_in;
    logic [WIDTH-1:0] one_in;
    logic [WIDTH-1:0] one_reg;
    logic             accept;
    logic             out_free;
    logic             load_out;
    logic             finish;

    logic             mm_start;
    logic [WIDTH-1:0] mm_a;
    logic [WIDTH-1:0] mm_b;
    logic [WIDTH-1:0] mm_m;
    mm_status_t       mm_status;
    logic [WIDTH-1:0] mm_product;

    assign base_in  = s_axis_tdata[WIDTH-1:0];
    assign exp_in   = s_axis_tdata[FIELD_W+WIDTH-1:FIELD_W];
    assign m_in     = s_axis_tdata[2*FIELD_W+WIDTH-1:2*FIELD_W];
    assign one_in   = WIDTH'(m_in != WIDTH'(1));
    assign one_reg  = WIDTH'(m_reg != WIDTH'(1));
    assign accept   = s_axis_tvalid && s_axis_tready;
    assign out_free = !out_valid_reg || m_axis_tready;
    assign load_out = (state_reg == ST_DONE) && out_free;

    modexp_mulmod u_mulmod (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mm_start),
        .op_a    (mm_a),
        .op_b    (mm_b),
        .op_m    (mm_m),
        .status  (mm_status),
        .product (mm_product)
    );

    always_comb
    begin
        state_next    = state_reg;
        exp_next      = exp_reg;
        bitcnt_next   = bitcnt_reg;
        mm_start      = 1'b0;
        mm_a          = mm_product;
        mm_b          = mm_product;
        mm_m          = m_reg;
        finish        = 1'b0;
        s_axis_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    exp_next    = exp_in;
                    bitcnt_next = CNT_W'(WIDTH - 1);
                    if (m_in == '0)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        // The base is reduced as (1 mod m) * base.
                        mm_start   = 1'b1;
                        mm_a       = one_in;
                        mm_b       = base_in;
                        mm_m       = m_in;
                        state_next = ST_REDUCE;
                    end
                end
            end
            ST_REDUCE:
            begin
                if (mm_status.done)
                begin
                    mm_start   = 1'b1;
                    mm_a       = one_reg;
                    mm_b       = one_reg;
                    state_next = ST_SQUARE;
                end
            end
            ST_SQUARE:
            begin
                if (mm_status.done)
                begin
                    if (exp_reg[WIDTH-1])
                    begin
                        mm_start   = 1'b1;
                        mm_b       = base_reg;
                        state_next = ST_MULT;
                    end
                    else if (bitcnt_reg == '0)
                    begin
                        finish     = 1'b1;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        mm_start    = 1'b1;
                        exp_next    = {exp_reg[WIDTH-2:0], 1'b0};
                        bitcnt_next = bitcnt_reg - CNT_W'(1);
                    end
                end
            end
            ST_MULT:
            begin
                if (mm_status.done)
                begin
                    if (bitcnt_reg == '0)
                    begin
                        finish     = 1'b1;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        mm_start    = 1'b1;
                        exp_next    = {exp_reg[WIDTH-2:0], 1'b0};
                        bitcnt_next = bitcnt_reg - CNT_W'(1);
                        state_next  = ST_SQUARE;
                    end
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        exp_reg    <= exp_next;
        bitcnt_reg <= bitcnt_next;
        if (accept)
        begin
            m_reg      <= m_in;
            result_reg <= '0;
            err_reg    <= (m_in == '0);
        end
        if ((state_reg == ST_REDUCE) && mm_status.done)
        begin
            base_reg <= mm_product;
        end
        if (finish)
        begin
            result_reg <= mm_product;
        end
        if (load_out)
        begin
            out_data_reg <= result_reg;
            out_err_reg  <= err_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = FIELD_W'(out_data_reg);
    assign m_axis_tuser  = out_err_reg;

    a_ready_unit_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !mm_status.busy)
        else $error("Input accepted while the multiplier is busy.");

    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        mm_status.done |-> (state_reg == ST_REDUCE || state_reg == ST_SQUARE ||
                            state_reg == ST_MULT))
        else $error("Multiplier finished outside a waiting state.");

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        mm_status.done |-> !mm_status.busy)
        else $error("Multiplier reports done while still busy.");

    a_error_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("Zero modulus transaction carries a nonzero result.");

endmodule

FILE: hw/rtl/modexp_mulmod.sv
// ----------------------------------------------------------------------------
// Bit-serial modular multiplier
// Forms (a * b) mod m by double-and-add, one multiplier bit per cycle from
// the most significant down; requires a < m and m nonzero.
// ----------------------------------------------------------------------------
module modexp_mulmod
    import modexp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [WIDTH-1:0] op_a,
    input  logic [WIDTH-1:0] op_b,
    input  logic [WIDTH-1:0] op_m,
    output mm_status_t       status,
    output logic [WIDTH-1:0] product
);

    logic [WIDTH-1:0] acc_reg;
    logic [WIDTH-1:0] acc_next;
    logic [WIDTH-1:0] a_reg;
    logic [WIDTH-1:0] b_reg;
    logic [WIDTH-1:0] m_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [WIDTH+1:0] sum_w;
    logic [WIDTH+1:0] m_ext;
    logic [WIDTH+1:0] m2_ext;
    logic [WIDTH+1:0] diff1;
    logic [WIDTH+1:0] diff2;
    logic [WIDTH-1:0] addend;

    // The partial sum 2*acc + a stays below 3*m, so at most 2*m comes off.
    always_comb
    begin
        addend = b_reg[WIDTH-1] ? a_reg : '0;
        sum_w  = {1'b0, acc_reg, 1'b0} + {2'b00, addend};
        m_ext  = {2'b00, m_reg};
        m2_ext = {1'b0, m_reg, 1'b0};
        diff1  = sum_w - m_ext;
        diff2  = sum_w - m2_ext;
        if (sum_w >= m2_ext)
        begin
            acc_next = diff2[WIDTH-1:0];
        end
        else if (sum_w >= m_ext)
        begin
            acc_next = diff1[WIDTH-1:0];
        end
        else
        begin
            acc_next = sum_w[WIDTH-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(WIDTH - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy_reg)
        begin
            acc_reg <= '0;
            a_reg   <= op_a;
            b_reg   <= op_b;
            m_reg   <= op_m;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
            b_reg   <= {b_reg[WIDTH-2:0], 1'b0};
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign product     = acc_reg;

endmodule
